### sv/tkh_pkg.sv
// Shared definitions for the top-k score heap: sizes, entry type, codes and
// the entry ordering function. Used by the top level and its checker.
package tkh_pkg;

    // Capacity of the heap and width of the stored node id.
    localparam int K_MAX    = 16;
    localparam int ID_BITS  = 24;

    // Port widths fixed by the interface.
    localparam int NODE_W   = 24;
    localparam int SCORE_W  = 17;
    localparam int CFG_W    = 5;

    // Derived widths.
    localparam int ID_W     = (ID_BITS < NODE_W) ? ID_BITS : NODE_W;
    localparam int ADDR_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CNT_W    = $clog2(K_MAX + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int ENTRY_W  = ID_W + SCORE_W;

    // Operation codes of an input transaction.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // One heap entry as stored in memory.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_entry;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT_RD,
        S_ROOT_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_SCAN,
        S_PUT
    } t_state;

    // True if entry a ranks below entry b: lower score, or larger id at equal score.
    function automatic logic weaker(input t_entry a, input t_entry b);
        weaker = (a.score < b.score) || ((a.score == b.score) && (a.id > b.id));
    endfunction

endpackage

### sv/tkh_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered
// read data. No dependencies.
module tkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register both read ports.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

### sv/top_k_score_heap.sv
// Top level of the top-k score heap: controller, heap memory and ranked drain.
// Depends on tkh_pkg and tkh_ram.
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_stall       i_operation, i_node_id, i_score
//  result    out        o_valid / i_stall       o_out_node, o_out_score,
//                                               o_out_valid, o_last
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_active_k
//
// An insert into a heap that is not full moves the hole up from the first free
// slot, reading and comparing one parent per level, until the candidate settles
// under its parent or at the root. A full heap reads the root and drops a
// candidate that does not beat it; otherwise the candidate replaces the root and
// sinks, reading both children per level, until it settles. A drain scans the n
// filled entries once per filled slot before loading that slot into the result
// register, and loads each empty slot directly; the result side can stall it.
// Reset is synchronous and clears control state only; the heap memory needs no
// clearing since entries at or beyond the fill count are never read. A
// configuration write waits until the block is idle and no result is pending.
module top_k_score_heap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [tkh_pkg::NODE_W-1:0]  i_node_id,
    input  logic [tkh_pkg::SCORE_W-1:0] i_score,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tkh_pkg::NODE_W-1:0]  o_out_node,
    output logic [tkh_pkg::SCORE_W-1:0] o_out_score,
    output logic                        o_out_valid,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tkh_pkg::CFG_W-1:0]   i_cfg_active_k
);

    import tkh_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_fill, n_fill;
    t_entry              r_cand, n_cand;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]    r_slot, n_slot;
    logic [CNT_W-1:0]    r_j, n_j;
    logic                r_rd_v, n_rd_v;
    logic [ADDR_W-1:0]   r_rd_idx, n_rd_idx;
    t_entry              r_best, n_best;
    logic                r_best_v, n_best_v;
    logic [ADDR_W-1:0]   r_best_idx, n_best_idx;
    logic [K_MAX-1:0]    r_mark, n_mark;
    logic                r_ov, n_ov;
    t_entry              r_out, n_out;
    logic                r_out_v, n_out_v;
    logic                r_last, n_last;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_entry              wr_data;
    logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
    logic [ENTRY_W-1:0]  rd_raw_a, rd_raw_b;
    t_entry              rd_a, rd_b;

    logic                in_acc, cfg_acc, out_free, is_last_slot;
    logic [CNT_W-1:0]    cfg_k;
    logic [ADDR_W-1:0]   parent;
    logic [CHILD_W-1:0]  child;
    logic [CHILD_W-1:0]  child_r;
    logic [1:0]          low_sel;
    t_entry              low_ent;

    // Heap storage, one entry per slot.
    tkh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (K_MAX)
    ) u_heap_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .o_rd_data_a (rd_raw_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_b (rd_raw_b)
    );

    assign rd_a = t_entry'(rd_raw_a);
    assign rd_b = t_entry'(rd_raw_b);

    // Handshakes. The block takes work only while idle.
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ov;
    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign in_acc      = i_valid && !o_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_ov || !i_stall;

    // Effective k: zero reads as one, values above capacity saturate.
    always_comb begin
        if (i_cfg_active_k == '0) begin
            cfg_k = CNT_W'(1);
        end else if (int'(i_cfg_active_k) > K_MAX) begin
            cfg_k = CNT_W'(K_MAX);
        end else begin
            cfg_k = CNT_W'(i_cfg_active_k);
        end
    end

    // Tree neighbors of the current hole position.
    assign parent       = (r_pos - ADDR_W'(1)) >> 1;
    assign child        = {1'b0, r_pos, 1'b1};
    assign child_r      = child + CHILD_W'(1);
    assign is_last_slot = (r_slot == (r_k - CNT_W'(1)));

    // Smallest of the hole candidate and its two children.
    always_comb begin
        low_sel = 2'd0;
        low_ent = r_cand;
        if (weaker(rd_a, low_ent)) begin
            low_sel = 2'd1;
            low_ent = rd_a;
        end
        if ((child_r < CHILD_W'(r_k)) && weaker(rd_b, low_ent)) begin
            low_sel = 2'd2;
            low_ent = rd_b;
        end
    end

    // Next state, memory control and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_fill     = r_fill;
        n_cand     = r_cand;
        n_pos      = r_pos;
        n_slot     = r_slot;
        n_j        = r_j;
        n_rd_v     = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_best     = r_best;
        n_best_v   = r_best_v;
        n_best_idx = r_best_idx;
        n_mark     = r_mark;
        n_ov       = r_ov && i_stall;
        n_out      = r_out;
        n_out_v    = r_out_v;
        n_last     = r_last;
        wr_en      = 1'b0;
        wr_addr    = r_pos;
        wr_data    = r_cand;
        rd_addr_a  = '0;
        rd_addr_b  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_k    = cfg_k;
                    n_fill = '0;
                end
                if (in_acc) begin
                    n_cand.id    = i_node_id[ID_W-1:0];
                    n_cand.score = i_score;
                    if (i_operation == OP_DRAIN) begin
                        n_slot   = '0;
                        n_j      = '0;
                        n_best_v = 1'b0;
                        n_mark   = '0;
                        n_state  = (r_fill == '0) ? S_PUT : S_SCAN;
                    end else if (r_fill < r_k) begin
                        n_pos   = r_fill[ADDR_W-1:0];
                        n_state = S_UP_RD;
                    end else begin
                        n_state = S_ROOT_RD;
                    end
                end
            end

            // Sift up: fetch the parent of the hole, or settle at the root.
            S_UP_RD: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    n_fill  = r_fill + CNT_W'(1);
                    n_state = S_IDLE;
                end else begin
                    rd_addr_a = parent;
                    n_state   = S_UP_CMP;
                end
            end

            // Move the parent down if the candidate ranks below it.
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (weaker(r_cand, rd_a)) begin
                    wr_data = rd_a;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_fill  = r_fill + CNT_W'(1);
                    n_state = S_IDLE;
                end
            end

            S_ROOT_RD: begin
                rd_addr_a = '0;
                n_state   = S_ROOT_CMP;
            end

            // A full heap takes the candidate only if it beats the root.
            S_ROOT_CMP: begin
                if (weaker(rd_a, r_cand)) begin
                    n_pos   = '0;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // Sift down: fetch both children, or settle at a leaf.
            S_DN_RD: begin
                if (child < CHILD_W'(r_k)) begin
                    rd_addr_a = child[ADDR_W-1:0];
                    rd_addr_b = child_r[ADDR_W-1:0];
                    n_state   = S_DN_CMP;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // Lift the weaker child into the hole, or place the candidate.
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (low_sel == 2'd0) begin
                    n_state = S_IDLE;
                end else begin
                    wr_data = low_ent;
                    n_pos   = (low_sel == 2'd1) ? child[ADDR_W-1:0] : child_r[ADDR_W-1:0];
                    n_state = S_DN_RD;
                end
            end

            // Scan the filled entries for the strongest one not yet emitted.
            S_SCAN: begin
                if (r_j < r_fill) begin
                    rd_addr_a = r_j[ADDR_W-1:0];
                    n_rd_v    = 1'b1;
                    n_rd_idx  = r_j[ADDR_W-1:0];
                    n_j       = r_j + CNT_W'(1);
                end
                if (r_rd_v && !r_mark[r_rd_idx] && (!r_best_v || weaker(r_best, rd_a))) begin
                    n_best     = rd_a;
                    n_best_v   = 1'b1;
                    n_best_idx = r_rd_idx;
                end
                if ((r_j == r_fill) && !r_rd_v) begin
                    n_state = S_PUT;
                end
            end

            // Load one ranked slot into the output register.
            S_PUT: begin
                if (out_free) begin
                    n_ov   = 1'b1;
                    n_last = is_last_slot;
                    if (r_slot < r_fill) begin
                        n_out               = r_best;
                        n_out_v             = 1'b1;
                        n_mark[r_best_idx]  = 1'b1;
                    end else begin
                        n_out   = '0;
                        n_out_v = 1'b0;
                    end
                    if (is_last_slot) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_slot = r_slot + CNT_W'(1);
                        if ((r_slot + CNT_W'(1)) < r_fill) begin
                            n_j      = '0;
                            n_best_v = 1'b0;
                            n_state  = S_SCAN;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= CNT_W'(K_MAX);
            r_fill   <= '0;
            r_rd_v   <= 1'b0;
            r_best_v <= 1'b0;
            r_mark   <= '0;
            r_ov     <= 1'b0;
            r_slot   <= '0;
            r_j      <= '0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_fill   <= n_fill;
            r_rd_v   <= n_rd_v;
            r_best_v <= n_best_v;
            r_mark   <= n_mark;
            r_ov     <= n_ov;
            r_slot   <= n_slot;
            r_j      <= n_j;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cand     <= n_cand;
        r_pos      <= n_pos;
        r_rd_idx   <= n_rd_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_out      <= n_out;
        r_out_v    <= n_out_v;
        r_last     <= n_last;
    end

    // Result port.
    assign o_valid     = r_ov;
    assign o_out_node  = NODE_W'(r_out.id);
    assign o_out_score = r_out.score;
    assign o_out_valid = r_out_v;
    assign o_last      = r_last;

endmodule

### sv/tkh_checker.sv
// Port-level checks for the top-k score heap, attached by a bind statement.
// Depends on tkh_pkg and top_k_score_heap.
module tkh_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic                        i_operation,
    input  logic [tkh_pkg::NODE_W-1:0]  i_node_id,
    input  logic [tkh_pkg::SCORE_W-1:0] i_score,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [tkh_pkg::NODE_W-1:0]  o_out_node,
    input  logic [tkh_pkg::SCORE_W-1:0] o_out_score,
    input  logic                        o_out_valid,
    input  logic                        o_last,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [tkh_pkg::CFG_W-1:0]   i_cfg_active_k
);

    import tkh_pkg::*;

    // A stalled result transaction holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_node) && $stable(o_out_score)
            && $stable(o_out_valid) && $stable(o_last))
        else $error("stalled result changed");

    // Every accepted input transaction leaves the input side stalled in the cycle after it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted back to back");

    // Empty slots carry zero payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> (o_out_node == '0) && (o_out_score == '0))
        else $error("empty slot with nonzero payload");

    // Within a drain, an empty slot is never followed by a filled one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_out_valid && !o_last |=> !(o_valid && o_out_valid))
        else $error("filled slot after empty slot");

    // Configuration is taken only while the input side is held off.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> o_stall)
        else $error("configuration write overlaps input transaction");

endmodule

bind top_k_score_heap tkh_checker u_tkh_checker (.*);

### verif/tb_top_k_score_heap.sv
`timescale 1ns / 100ps
// Self-checking testbench for top_k_score_heap: directed and random insert and drain
// transactions, checked against a behavioral top-k heap. Depends on tkh_pkg and the RTL.
module tb_top_k_score_heap;
    import tkh_pkg::*;

    // Leave a margin after the slowest root replacement before config writes.
    localparam int SETTLE_CYCLES = 32;
    localparam int QUIET_LIMIT   = 4000;

    // One ranked slot of a drain as it should appear on the result channel.
    typedef struct {
        logic [NODE_W-1:0]  node;
        logic [SCORE_W-1:0] score;
        logic               filled;
        logic               last;
    } t_slot;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_operation;
    logic [NODE_W-1:0]   i_node_id;
    logic [SCORE_W-1:0]  i_score;
    logic                o_valid;
    logic                i_stall;
    logic [NODE_W-1:0]   o_out_node;
    logic [SCORE_W-1:0]  o_out_score;
    logic                o_out_valid;
    logic                o_last;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_active_k;

    // Shadow heap, its k setting and the ranked slots still to arrive.
    logic [ID_W-1:0]     kept_id [K_MAX];
    logic [SCORE_W-1:0]  kept_score [K_MAX];
    int                  kept_count;
    logic [CFG_W-1:0]    k_setting;
    t_slot               ranked_slots[$];

    int                  fail_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  quiet_cycles;

    top_k_score_heap dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_node_id      (i_node_id),
        .i_score        (i_score),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_node     (o_out_node),
        .o_out_score    (o_out_score),
        .o_out_valid    (o_out_valid),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_active_k (i_cfg_active_k)
    );

    // Free-running clock, 20 ns period.
    always #10 i_clk = ~i_clk;

    // The result side stalls at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Entry a ranks below entry b: lower score, or larger id at equal score.
    function automatic bit ranks_below(logic [SCORE_W-1:0] sa, logic [ID_W-1:0] ia,
                                       logic [SCORE_W-1:0] sb, logic [ID_W-1:0] ib);
        return (sa < sb) || ((sa == sb) && (ia > ib));
    endfunction

    // The register value in use, clamped to 1..K_MAX.
    function automatic int k_in_use();
        if (k_setting == 0) return 1;
        if (k_setting > K_MAX) return K_MAX;
        return int'(k_setting);
    endfunction

    function automatic void swap_kept(int a, int b);
        logic [ID_W-1:0]    tid;
        logic [SCORE_W-1:0] tsc;
        tid = kept_id[a];
        kept_id[a] = kept_id[b];
        kept_id[b] = tid;
        tsc = kept_score[a];
        kept_score[a] = kept_score[b];
        kept_score[b] = tsc;
    endfunction

    // Insert: append and sift up while not full, else replace a weaker root and sift down.
    function automatic void keep_candidate(logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc);
        int k;
        int pos;
        int up;
        int low;
        int c;
        k = k_in_use();
        if (kept_count < k) begin
            pos = kept_count;
            kept_id[pos] = id;
            kept_score[pos] = sc;
            kept_count++;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (!ranks_below(kept_score[pos], kept_id[pos], kept_score[up], kept_id[up]))
                    break;
                swap_kept(pos, up);
                pos = up;
            end
        end else if (ranks_below(kept_score[0], kept_id[0], sc, id)) begin
            kept_id[0] = id;
            kept_score[0] = sc;
            pos = 0;
            while (2 * pos + 1 < k) begin
                low = pos;
                c = 2 * pos + 1;
                if (ranks_below(kept_score[c], kept_id[c], kept_score[low], kept_id[low]))
                    low = c;
                if (c + 1 < k && ranks_below(kept_score[c + 1], kept_id[c + 1],
                                             kept_score[low], kept_id[low]))
                    low = c + 1;
                if (low == pos)
                    break;
                swap_kept(pos, low);
                pos = low;
            end
        end
    endfunction

    // Drain: queue k slots, filled ones strongest first, then empty ones; clear the heap.
    function automatic void rank_and_clear();
        logic [ID_W-1:0]    ids [K_MAX];
        logic [SCORE_W-1:0] scs [K_MAX];
        logic [ID_W-1:0]    tid;
        logic [SCORE_W-1:0] tsc;
        int                 k;
        int                 best;
        int                 i;
        int                 j;
        t_slot              s;
        k = k_in_use();
        ids = kept_id;
        scs = kept_score;
        for (i = 0; i < kept_count; i++) begin
            best = i;
            for (j = i + 1; j < kept_count; j++)
                if (ranks_below(scs[best], ids[best], scs[j], ids[j]))
                    best = j;
            tid = ids[i]; ids[i] = ids[best]; ids[best] = tid;
            tsc = scs[i]; scs[i] = scs[best]; scs[best] = tsc;
        end
        for (i = 0; i < k; i++) begin
            if (i < kept_count) begin
                s.node   = NODE_W'(ids[i]);
                s.score  = scs[i];
                s.filled = 1'b1;
            end else begin
                s.node   = '0;
                s.score  = '0;
                s.filled = 1'b0;
            end
            s.last = (i == k - 1);
            ranked_slots.push_back(s);
        end
        kept_count = 0;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Each result transaction is compared with the oldest queued slot.
    always @(posedge i_clk) begin : result_check
        t_slot want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (ranked_slots.size() == 0) begin
                $error("unexpected result: node 0x%0h score 0x%0h valid %0b last %0b",
                       o_out_node, o_out_score, o_out_valid, o_last);
                fail_count++;
            end else begin
                want = ranked_slots.pop_front();
                compare_field("out_node", 32'(want.node), 32'(o_out_node));
                compare_field("out_score", 32'(want.score), 32'(o_out_score));
                compare_field("out_valid", 32'(want.filled), 32'(o_out_valid));
                compare_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind completes for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top_k_score_heap: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one input transaction after a random gap; valid is left high afterwards.
    task automatic send_item(input logic op, input logic [NODE_W-1:0] id,
                             input logic [SCORE_W-1:0] sc);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_node_id   <= id;
        i_score     <= sc;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_DRAIN)
            rank_and_clear();
        else
            keep_candidate(id[ID_W-1:0], sc);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every queued slot has come out.
    task automatic quiesce();
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (ranked_slots.size() == 0);
        @(negedge i_clk);
    endtask

    // Write active_k once the block is idle; the write also empties the heap.
    task automatic write_k(input logic [CFG_W-1:0] value);
        quiesce();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_active_k <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        k_setting  = value;
        kept_count = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset value of k: drain of an empty heap, then extremes of id and score and ties.
    task automatic test_reset_k_and_ties();
        send_item(OP_DRAIN, '0, '0);
        send_item(OP_INSERT, 24'hFFFFFF, 17'd0);
        send_item(OP_INSERT, 24'h000000, 17'h1FFFF);
        send_item(OP_INSERT, 24'h123456, 17'd65536);
        send_item(OP_INSERT, 24'h000001, 17'd65536);
        send_item(OP_INSERT, 24'hABCDEF, 17'd0);
        send_item(OP_DRAIN, 24'h5A5A5A, 17'h0A5A5);
    endtask

    // Full heap of three: an equal pair is dropped, a smaller id at equal score
    // replaces the root, and a weaker candidate is dropped.
    task automatic test_full_heap_replace();
        write_k(5'd3);
        send_item(OP_INSERT, 24'd10, 17'd100);
        send_item(OP_INSERT, 24'd20, 17'd100);
        send_item(OP_INSERT, 24'd30, 17'd200);
        send_item(OP_INSERT, 24'd20, 17'd100);
        send_item(OP_INSERT, 24'd15, 17'd100);
        send_item(OP_INSERT, 24'd5, 17'd50);
        send_item(OP_DRAIN, '0, '0);
    endtask

    // Register values out of range: zero acts as one, above K_MAX acts as K_MAX.
    task automatic test_k_bounds();
        write_k(5'd0);
        send_item(OP_INSERT, 24'd7, 17'd5);
        send_item(OP_INSERT, 24'd8, 17'd6);
        send_item(OP_DRAIN, '0, '0);
        write_k(5'd31);
        send_item(OP_INSERT, 24'd1, 17'd1);
        send_item(OP_DRAIN, '0, '0);
    endtask

    // Random k, mostly small; zero, K_MAX and values above it now and then.
    function automatic logic [CFG_W-1:0] pick_k();
        case ($urandom_range(9, 0))
            0:       return 5'd0;
            1:       return 5'd31;
            2:       return 5'd16;
            3:       return 5'd17;
            default: return CFG_W'($urandom_range(8, 1));
        endcase
    endfunction

    // Bursts of inserts followed by a drain, with k changed between some bursts.
    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
        int                 sent;
        int                 burst;
        int                 b;
        logic [NODE_W-1:0]  id;
        logic [SCORE_W-1:0] sc;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(2, 0) == 0)
                write_k(pick_k());
            burst = $urandom_range(2 * k_in_use() + 2, 0);
            for (b = 0; b < burst; b++) begin
                case ($urandom_range(7, 0))
                    // Few ids and scores, so ties and equal pairs are common.
                    0, 1: begin
                        id = NODE_W'($urandom_range(3, 0));
                        case ($urandom_range(3, 0))
                            0:       sc = 17'd0;
                            1:       sc = 17'd1;
                            2:       sc = 17'd65535;
                            default: sc = 17'd65536;
                        endcase
                    end
                    // Scores above 1.0 are kept as raw values.
                    2: begin
                        id = NODE_W'($urandom);
                        sc = SCORE_W'($urandom_range(17'h1FFFF, 65537));
                    end
                    default: begin
                        id = NODE_W'($urandom);
                        sc = SCORE_W'($urandom_range(65536, 0));
                    end
                endcase
                send_item(OP_INSERT, id, sc);
                sent++;
            end
            send_item(OP_DRAIN, NODE_W'($urandom), SCORE_W'($urandom));
            sent++;
            if ($urandom_range(3, 0) == 0)
                quiesce();
        end
        quiesce();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_INSERT;
        i_node_id      = '0;
        i_score        = '0;
        i_stall        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_active_k = '0;
        kept_count     = 0;
        k_setting      = 5'd16;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_k_and_ties();
        test_full_heap_replace();
        test_k_bounds();
        test_random_phase(0, 0, 103);
        test_random_phase(64, 0, 103);
        test_random_phase(0, 64, 103);
        test_random_phase(21, 21, 103);

        quiesce();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_top_k_score_heap: PASS");
        else
            $display("tb_top_k_score_heap: FAIL");
        $finish;
    end

endmodule

### files.f
sv/tkh_pkg.sv
sv/tkh_ram.sv
sv/top_k_score_heap.sv
sv/tkh_checker.sv
verif/tb_top_k_score_heap.sv
